// ===== rtl/subnet_usage_monitor_core_macros.svh =====
// Assertion helpers, sampled on clk, off while rst is high.
`ifndef SUBNET_USAGE_MONITOR_CORE_MACROS_SVH
`define SUBNET_USAGE_MONITOR_CORE_MACROS_SVH

// Same-cycle implication.
`define SUM_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("subnet usage monitor: assertion failed");

// Next-cycle implication.
`define SUM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("subnet usage monitor: assertion failed");

`endif

// ===== rtl/sum_pkg.sv =====
package sum_pkg;

  localparam int SLOTS      = 4;
  localparam int SEEN_DEPTH = 256;
  localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
  localparam int FILL_W     = SEEN_AW + 1;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 6;
  localparam int PREFIX_W   = ADDR_W + LEN_W;
  localparam int CMP_W      = ADDR_W + 1;
  localparam int CNT_W      = 9;
  localparam int SLOT_W     = 2;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PREFIX_W;
  localparam int QDEPTH     = 2;
  localparam int Q_AW       = $clog2(QDEPTH);
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_D     = 3'd4;

  typedef logic [PREFIX_W-1:0] prefix_t;

  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    prefix_t [SLOTS-1:0]   prefix;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SLOTS-1:0]  hit;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [LEN_W-1:0] clamp_len(prefix_t p);
    logic [LEN_W-1:0] len;
    len = p[LEN_W-1:0];
    return (len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : len;
  endfunction

  function automatic logic [ADDR_W-1:0] mask_of(logic [LEN_W-1:0] len);
    return (len == '0) ? '0 : ({ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len));
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_cap(prefix_t p);
    return ~mask_of(clamp_len(p)) - ADDR_W'(1);
  endfunction

  function automatic logic is_host(prefix_t p, logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] bcast;
    m     = mask_of(clamp_len(p));
    net   = p[PREFIX_W-1:LEN_W] & m;
    bcast = net | ~m;
    return ((addr & m) == net) && (addr != net) && (addr != bcast);
  endfunction

  // Counts above SLOTS saturate naturally.
  function automatic logic [SLOTS-1:0] active_slots(logic [COUNT_W-1:0] count);
    logic [SLOTS-1:0] act;
    for (int i = 0; i < SLOTS; i++) begin
      act[i] = (int'(count) > i);
    end
    return act;
  endfunction

endpackage

// ===== rtl/sum_ram.sv =====
module sum_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sum_queue.sv =====
module sum_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sum_pkg::job_t       push_data,
  input  logic                pop,
  output sum_pkg::job_t       pop_data,
  output sum_pkg::q_status_t  status
);

  sum_pkg::job_t               entries [sum_pkg::QDEPTH];
  logic [sum_pkg::Q_AW-1:0]    wptr;
  logic [sum_pkg::Q_AW-1:0]    rptr;
  logic [sum_pkg::Q_AW:0]      count;

  assign pop_data     = entries[rptr];
  assign status.full  = (count == (sum_pkg::Q_AW+1)'(sum_pkg::QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

// ===== rtl/sum_front.sv =====
module sum_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sum_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sum_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sum_pkg::ADDR_W-1:0]          s_tdata,
  input  sum_pkg::q_status_t                  q_status,
  output logic                                push,
  output sum_pkg::job_t                       push_data,
  output sum_pkg::cfg_t                       cfg
);

  logic [sum_pkg::SLOTS-1:0] hit;
  logic [sum_pkg::SLOTS-1:0] act;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sum_pkg::REG_PREFIX_COUNT: cfg.count     <= cfg_data[sum_pkg::COUNT_W-1:0];
        sum_pkg::REG_PREFIX_A:     cfg.prefix[0] <= cfg_data;
        sum_pkg::REG_PREFIX_B:     cfg.prefix[1] <= cfg_data;
        sum_pkg::REG_PREFIX_C:     cfg.prefix[2] <= cfg_data;
        sum_pkg::REG_PREFIX_D:     cfg.prefix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign act = sum_pkg::active_slots(cfg.count);

  always_comb begin
    for (int i = 0; i < sum_pkg::SLOTS; i++) begin
      hit[i] = act[i] && sum_pkg::is_host(cfg.prefix[i], s_tdata);
    end
  end

  // Addresses outside every prefix are dropped here.
  assign s_tready       = !q_status.full;
  assign push           = s_tvalid && s_tready && (|hit);
  assign push_data.addr = s_tdata;
  assign push_data.hit  = hit;

endmodule

// ===== rtl/sum_back.sv =====
module sum_back (
  input  logic                               clk,
  input  logic                               rst,
  input  sum_pkg::cfg_t                      cfg,
  input  sum_pkg::q_status_t                 q_status,
  output logic                               pop,
  input  sum_pkg::job_t                      pop_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sum_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [sum_pkg::OUT_USER_W-1:0]     m_tuser,
  output logic                               m_tlast,
  output logic [sum_pkg::FILL_W-1:0]         fill
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]                    state;
  logic [sum_pkg::ADDR_W-1:0]    job_addr;
  logic [sum_pkg::SLOTS-1:0]     pending;
  logic [sum_pkg::FILL_W-1:0]    iss;
  logic                          found;
  logic                          inc;
  logic                          full_flag;
  logic [sum_pkg::CNT_W-1:0]     usage [sum_pkg::SLOTS];
  logic [sum_pkg::SLOTS-1:0]     warned;

  logic                          re;
  logic [sum_pkg::SEEN_AW-1:0]   raddr;
  logic                          we;
  logic [sum_pkg::ADDR_W-1:0]    rdata;

  logic [sum_pkg::SLOT_W-1:0]    sel;
  logic [sum_pkg::ADDR_W-1:0]    cap;
  logic [sum_pkg::CNT_W-1:0]     u_cur;
  logic [sum_pkg::CNT_W-1:0]     u_next;
  logic                          warn;
  logic [sum_pkg::SLOTS-1:0]     pending_next;
  logic                          out_load;
  logic                          store_room;

  sum_ram #(
    .WIDTH (sum_pkg::ADDR_W),
    .DEPTH (sum_pkg::SEEN_DEPTH)
  ) u_seen (
    .clk   (clk),
    .we    (we),
    .waddr (fill[sum_pkg::SEEN_AW-1:0]),
    .wdata (job_addr),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pop        = (state == ST_IDLE) && !q_status.empty;
  assign store_room = (fill != sum_pkg::FILL_W'(sum_pkg::SEEN_DEPTH));
  assign we         = (state == ST_DECIDE) && !found && store_room;

  always_comb begin
    re    = 1'b0;
    raddr = iss[sum_pkg::SEEN_AW-1:0];
    if (pop && (fill != '0)) begin
      re    = 1'b1;
      raddr = '0;
    end else if ((state == ST_SCAN) && (rdata != job_addr) && (iss != fill)) begin
      re = 1'b1;
    end
  end

  // Lowest pending slot first keeps register order.
  always_comb begin
    sel = '0;
    for (int i = sum_pkg::SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel = sum_pkg::SLOT_W'(i);
      end
    end
    cap    = sum_pkg::prefix_cap(cfg.prefix[sel]);
    u_cur  = usage[sel];
    u_next = (inc && (u_cur != sum_pkg::COUNT_MAX)) ? u_cur + 1'b1 : u_cur;
    warn   = !warned[sel] &&
             (sum_pkg::CMP_W'({u_next, 1'b0}) >= sum_pkg::CMP_W'(cap));
    pending_next = pending;
    pending_next[sel] = 1'b0;
  end

  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      warned   <= '0;
      m_tvalid <= 1'b0;
      pending  <= '0;
      for (int i = 0; i < sum_pkg::SLOTS; i++) begin
        usage[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            pending <= pop_data.hit;
            iss     <= sum_pkg::FILL_W'(1);
            state   <= (fill == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if ((rdata == job_addr) || (iss == fill)) begin
            state <= ST_DECIDE;
          end else begin
            iss <= iss + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (we) begin
            fill <= fill + 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            usage[sel] <= u_next;
            if (warn) begin
              warned[sel] <= 1'b1;
            end
            pending <= pending_next;
            if (pending_next == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_addr <= pop_data.addr;
      found    <= 1'b0;
    end else if ((state == ST_SCAN) && (rdata == job_addr)) begin
      found <= 1'b1;
    end
    if (state == ST_DECIDE) begin
      inc       <= !found && store_room;
      full_flag <= !found && !store_room;
    end
    if (out_load) begin
      m_tdata <= sum_pkg::OUT_DATA_W'({cap, u_next, sel});
      m_tuser <= {full_flag, warn};
      m_tlast <= (pending_next == '0);
    end
  end

endmodule

// ===== rtl/subnet_usage_monitor_core.sv =====
// Per address: the job is dequeued, then stored addresses are read one by one until a hit
// (up to the fill count, at most 256), the store is updated, then one result goes out
// per matching prefix, waiting while the output is stalled. The search is serial, through
// the one read port of the store; up to two addresses queue behind the search. Reset
// clears the prefixes, counts, flags, store fill and queue; store contents are not
// cleared and no clearing pass runs.
`include "subnet_usage_monitor_core_macros.svh"

module subnet_usage_monitor_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sum_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sum_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sum_pkg::ADDR_W-1:0]        s_tdata,   // host_addr
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // prefix_index[1:0], used_count[10:2], host_capacity[42:11], zero pad
  output logic [sum_pkg::OUT_DATA_W-1:0]    m_tdata,
  // half_warning[0], store_full[1]
  output logic [sum_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                              m_tlast    // last_result
);

  sum_pkg::cfg_t                 cfg;
  sum_pkg::q_status_t            q_status;
  sum_pkg::job_t                 push_data;
  sum_pkg::job_t                 pop_data;
  logic                          push;
  logic                          pop;
  logic [sum_pkg::FILL_W-1:0]    fill;

  sum_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data),
    .cfg       (cfg)
  );

  sum_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  sum_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .pop       (pop),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .fill      (fill)
  );

  `SUM_ASSERT_HOLDS(a_fill_bound, 1'b1, fill <= sum_pkg::FILL_W'(sum_pkg::SEEN_DEPTH))
  `SUM_ASSERT_HOLDS(a_full_only_when_full, m_tvalid && m_tuser[1], fill == sum_pkg::FILL_W'(sum_pkg::SEEN_DEPTH))
  `SUM_ASSERT_NEXT(a_fill_step, 1'b1, (fill == $past(fill)) || (fill == $past(fill) + 1'b1))
  `SUM_ASSERT_HOLDS(a_pop_nonempty, pop, !q_status.empty)

endmodule
